// ===== hw/rtl/esc_pkg.sv =====
// Shared constants and helper function of the epoch-seconds to calendar converter.
package esc_pkg;

	// Reciprocals for exact division by constants: q = (x * RECIP) >> SHIFT.
	localparam logic [25:0] DAY_RECIP     = 26'd50903317; // (t >> 7) / 675, shift 35
	localparam logic [9:0]  DAY_REM_DIV   = 10'd675;
	localparam logic [16:0] RECIP_365     = 17'd91930;    // (doe >> 2) / 365, shift 25
	localparam logic [18:0] RECIP_YEAR    = 19'd367720;   // n / 365, shift 27
	localparam logic [11:0] RECIP_153     = 12'd3427;     // v / 153, shift 19
	localparam logic [15:0] RECIP_15_WIDE = 16'd34953;    // (fract >> 2) / 15, shift 19
	localparam logic [9:0]  RECIP_15_NARR = 10'd547;      // (minutes >> 2) / 15, shift 13

	// Day counts of the March-based civil calendar.
	localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
	localparam logic [19:0] ERA4_START    = 20'd584388;
	localparam logic [19:0] ERA5_START    = 20'd730485;
	localparam logic [17:0] CENT_DAYS     = 18'd36524;
	localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
	localparam logic [17:0] YEAR_DAYS     = 18'd365;

	// First day of each March-based month within the year.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/esc_split.sv =====
// Front stages: zone offset, clamp, and split into whole days and seconds of the day.
module esc_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [31:0]        epoch_seconds,
	input  logic signed [16:0] zone,
	output logic               valid_s3,
	output logic [15:0]        days_s3,
	output logic [16:0]        fract_s3
);

	logic signed [33:0] sum;
	logic [31:0]        t_clamp;
	logic [31:0]        t_s1;
	logic [50:0]        prod_s2;
	logic [24:0]        x_s2;
	logic [6:0]         low_s2;
	logic               valid_s1, valid_s2;
	logic [15:0]        days;
	logic [24:0]        rem_full;

	always_comb begin
		sum = $signed({2'b00, epoch_seconds}) + $signed({{17{zone[16]}}, zone});
		priority if (sum[33]) begin
			t_clamp = 32'd0;
		end else if (sum[32]) begin
			t_clamp = 32'hFFFF_FFFF;
		end else begin
			t_clamp = sum[31:0];
		end
	end

	assign days     = prod_s2[50:35];
	assign rem_full = x_s2 - 25'(days) * 25'(esc_pkg::DAY_REM_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1     <= t_clamp;
		prod_s2  <= 51'(t_s1[31:7]) * 51'(esc_pkg::DAY_RECIP);
		x_s2     <= t_s1[31:7];
		low_s2   <= t_s1[6:0];
		days_s3  <= days;
		fract_s3 <= {rem_full[9:0], low_s2};
	end

endmodule

// ===== hw/rtl/esc_tod.sv =====
// Time-of-day stages: seconds of the day into hour, minute and second.
module esc_tod (
	input  logic        clk,
	input  logic [16:0] fract_s3,
	output logic [5:0]  second_s11,
	output logic [5:0]  minute_s11,
	output logic [4:0]  hour_s11
);

	logic [30:0] pf_s4;
	logic [16:0] fract_s4;
	logic [10:0] mt_s5;
	logic [5:0]  sec_s5, sec_s6, sec_s7, sec_s8, sec_s9, sec_s10;
	logic [18:0] pm_s6;
	logic [10:0] mt_s6;
	logic [5:0]  min_s7, min_s8, min_s9, min_s10;
	logic [4:0]  hour_s7, hour_s8, hour_s9, hour_s10;
	logic [10:0] mt;
	logic [16:0] sec_full;
	logic [4:0]  hour;
	logic [10:0] min_full;

	assign mt       = pf_s4[29:19];
	assign sec_full = fract_s4 - 17'(mt) * 17'd60;
	assign hour     = pm_s6[17:13];
	assign min_full = mt_s6 - 11'(hour) * 11'd60;

	always_ff @(posedge clk) begin
		pf_s4      <= 31'(fract_s3[16:2]) * 31'(esc_pkg::RECIP_15_WIDE);
		fract_s4   <= fract_s3;
		mt_s5      <= mt;
		sec_s5     <= sec_full[5:0];
		pm_s6      <= 19'(mt_s5[10:2]) * 19'(esc_pkg::RECIP_15_NARR);
		mt_s6      <= mt_s5;
		sec_s6     <= sec_s5;
		hour_s7    <= hour;
		min_s7     <= min_full[5:0];
		sec_s7     <= sec_s6;
		// Delay line to line up with the date stages.
		hour_s8    <= hour_s7;
		min_s8     <= min_s7;
		sec_s8     <= sec_s7;
		hour_s9    <= hour_s8;
		min_s9     <= min_s8;
		sec_s9     <= sec_s8;
		hour_s10   <= hour_s9;
		min_s10    <= min_s9;
		sec_s10    <= sec_s9;
		hour_s11   <= hour_s10;
		minute_s11 <= min_s10;
		second_s11 <= sec_s10;
	end

endmodule

// ===== hw/rtl/esc_date.sv =====
// Date stages: days since 1970 into year, month and day of month.
module esc_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s3,
	input  logic [15:0] days_s3,
	output logic        valid_s11,
	output logic [4:0]  mday_s11,
	output logic [3:0]  month_s11,
	output logic [7:0]  year_s11
);

	logic [7:0]  valid_sr;
	logic [19:0] z;
	logic        era5;
	logic [19:0] doe_full;
	logic [17:0] doe_s4, doe_s5, doe_s6, doe_s7, doe_s8;
	logic        era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [32:0] p1_s5;
	logic [2:0]  b_s5;
	logic        c_s5;
	logic [17:0] n_s6;
	logic [36:0] pn_s7;
	logic [8:0]  yoe_s8, yoe_s9, yoe_s10;
	logic [8:0]  doy_s9, doy_s10;
	logic [22:0] pmp_s10;
	logic [2:0]  b_cnt;
	logic [1:0]  cent;
	logic [17:0] doy_full;
	logic [11:0] v;
	logic [3:0]  mp;
	logic [8:0]  mday_full;
	logic [3:0]  m0;
	logic [9:0]  yfull;

	assign z        = 20'(days_s3) + esc_pkg::DAYS_TO_EPOCH;
	assign era5     = z >= esc_pkg::ERA5_START;
	assign doe_full = z - (era5 ? esc_pkg::ERA5_START : esc_pkg::ERA4_START);

	// Number of whole centuries inside the era, 0 to 4.
	assign b_cnt = 3'(doe_s4 >= esc_pkg::CENT_DAYS)
		+ 3'(doe_s4 >= 18'(2 * esc_pkg::CENT_DAYS))
		+ 3'(doe_s4 >= 18'(3 * esc_pkg::CENT_DAYS))
		+ 3'(doe_s4 >= 18'(4 * esc_pkg::CENT_DAYS));

	assign cent = 2'(yoe_s8 >= 9'd100) + 2'(yoe_s8 >= 9'd200) + 2'(yoe_s8 >= 9'd300);
	assign doy_full = doe_s8
		- (18'(yoe_s8) * esc_pkg::YEAR_DAYS + 18'(yoe_s8[8:2]) - 18'(cent));

	assign v = 12'(doy_s9) * 12'd5 + 12'd2;

	assign mp        = pmp_s10[22:19];
	assign mday_full = doy_s10 - esc_pkg::month_start(mp) + 9'd1;
	assign m0        = (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
	// The first era of interest starts at 1600, so its years sit 400 below 2000.
	assign yfull = (era_s10 ? 10'(yoe_s10) : 10'(yoe_s10) - 10'd400)
		+ 10'(mp >= 4'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sr <= '0;
		end else begin
			valid_sr <= {valid_sr[6:0], valid_s3};
		end
	end

	assign valid_s11 = valid_sr[7];

	always_ff @(posedge clk) begin
		doe_s4    <= doe_full[17:0];
		era_s4    <= era5;
		p1_s5     <= 33'(doe_s4[17:2]) * 33'(esc_pkg::RECIP_365);
		b_s5      <= b_cnt;
		c_s5      <= doe_s4 == esc_pkg::ERA_LAST_DAY;
		doe_s5    <= doe_s4;
		era_s5    <= era_s4;
		n_s6      <= doe_s5 - 18'(p1_s5[32:25]) + 18'(b_s5) - 18'(c_s5);
		doe_s6    <= doe_s5;
		era_s6    <= era_s5;
		pn_s7     <= 37'(n_s6) * 37'(esc_pkg::RECIP_YEAR);
		doe_s7    <= doe_s6;
		era_s7    <= era_s6;
		yoe_s8    <= pn_s7[35:27];
		doe_s8    <= doe_s7;
		era_s8    <= era_s7;
		doy_s9    <= doy_full[8:0];
		yoe_s9    <= yoe_s8;
		era_s9    <= era_s8;
		pmp_s10   <= 23'(v) * 23'(esc_pkg::RECIP_153);
		doy_s10   <= doy_s9;
		yoe_s10   <= yoe_s9;
		era_s10   <= era_s9;
		mday_s11  <= mday_full[4:0];
		month_s11 <= m0;
		year_s11  <= yfull[7:0];
	end

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar.sv =====
// Top level of the epoch-seconds to calendar converter pipeline.
//
// Usage: drive an unsigned 32-bit count of seconds since 1970-01-01 on
// epoch_seconds and raise start for one cycle. A word is taken at every rising
// edge where start is high and busy is low. Busy never rises, so a new word can
// be given in every cycle and the block converts one timestamp per cycle.
// A word taken at one edge passes through the split and date register stages;
// done is high for exactly one cycle when its result is shown, while
// second, minute, hour, day_of_month, month and year_from_2000 hold the result.
// Results leave in the order the words came in. The receiver cannot
// stall the block; it must take each result in the cycle it is shown.
// The time-zone offset is written with cfg_we and cfg_wdata, a signed count of
// seconds that is added to every timestamp before the calendar split; write it
// only while no word is in flight. Asynchronous reset clears all valid bits, so
// no result appears until new words arrive, and sets the offset to zero.
// A result passes through eleven register stages, split and date path together.
module epoch_seconds_to_calendar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        epoch_seconds,
	input  logic               cfg_we,
	input  logic signed [16:0] cfg_wdata,
	output logic               done,
	output logic [5:0]         second,
	output logic [5:0]         minute,
	output logic [4:0]         hour,
	output logic [4:0]         day_of_month,
	output logic [3:0]         month,
	output logic signed [7:0]  year_from_2000
);

	logic signed [16:0] zone_q;
	logic               take;
	logic               valid_s3;
	logic [15:0]        days_s3;
	logic [16:0]        fract_s3;
	logic [7:0]         year_raw;

	// The pipeline never holds, so the block is always ready for a new word.
	assign busy = 1'b0;
	assign take = start && !busy;

	// Time-zone offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= '0;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// Stages one to three: add the offset, clamp to the 32-bit range, and split
	// into whole days and the seconds within the day.
	esc_split u_split (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (take),
		.epoch_seconds (epoch_seconds),
		.zone          (zone_q),
		.valid_s3      (valid_s3),
		.days_s3       (days_s3),
		.fract_s3      (fract_s3)
	);

	// Stages four to eleven, time of day: hours and minutes come from two
	// reciprocal multiplies and are then delayed to meet the date path.
	esc_tod u_tod (
		.clk        (clk),
		.fract_s3   (fract_s3),
		.second_s11 (second),
		.minute_s11 (minute),
		.hour_s11   (hour)
	);

	// Stages four to eleven, date: March-based era, year of era, day of year
	// and month, each split step behind its own register.
	esc_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.days_s3   (days_s3),
		.valid_s11 (done),
		.mday_s11  (day_of_month),
		.month_s11 (month),
		.year_s11  (year_raw)
	);

	assign year_from_2000 = $signed(year_raw);

endmodule
